// ----- src/mke_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mke_pkg: shared types and constants of the key envelope engine
// Field widths, keyboard geometry, MIDI codes and the curve table builder.
// ----------------------------------------------------------------------------
package mke_pkg;

	// Keyboard geometry and envelope scale
	localparam int LOW_KEY     = 36;
	localparam int KEY_OCTAVES = 5;
	localparam int FULL_LEVEL  = 1000;
	localparam int OCT_KEYS    = 12;
	localparam int NKEYS       = OCT_KEYS * KEY_OCTAVES;

	// Field widths
	localparam int KEY_W   = 6;
	localparam int LVL_W   = 11;
	localparam int BEND_W  = 14;
	localparam int MSQ_W   = 14;
	localparam int PROG_W  = 7;
	localparam int DATA_W  = 7;
	localparam int STAT_W  = 8;
	localparam int LEN_W   = 2;
	localparam int CHAN_W  = 5;
	localparam int TRN_W   = 5;
	localparam int CFG_DW  = 11;
	localparam int CFG_IW  = 2;
	localparam int HCNT_W  = $clog2(NKEYS + 1);
	localparam int OCT_W   = $clog2(KEY_OCTAVES + 1);
	localparam int NOTE_W  = 4;
	localparam int STEP_W  = KEY_OCTAVES;
	localparam int CURVE_AW    = $clog2(FULL_LEVEL + 1);
	localparam int CURVE_DEPTH = 1 << CURVE_AW;
	localparam int CURVE_W     = $clog2(FULL_LEVEL + 1);

	// Configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_MIDI_CHANNEL = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_TRANSPOSE    = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_PERCUSSION   = 2'd2;

	// MIDI message types (upper status nibble) and controllers
	localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
	localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
	localparam logic [3:0] MSG_CTRL     = 4'hB;
	localparam logic [3:0] MSG_PROGRAM  = 4'hC;
	localparam logic [3:0] MSG_BEND     = 4'hE;
	localparam logic [DATA_W-1:0] CC_VOLUME    = 7'd7;
	localparam logic [DATA_W-1:0] CC_SOUND_OFF = 7'd120;
	localparam logic [DATA_W-1:0] CC_NOTES_OFF = 7'd123;
	localparam logic [LEN_W-1:0]  LEN_SHORT    = 2'd2;
	localparam logic [LEN_W-1:0]  LEN_FULL     = 2'd3;

	// Per-key control handed to the level unit
	typedef struct packed {
		logic             held;
		logic             perc;
		logic [OCT_W-1:0] oct;
	} lvl_ctl_t;

	// Raised-cosine table, built at elaboration
	typedef logic [CURVE_W-1:0] curve_tab_t [0:CURVE_DEPTH-1];

	localparam logic [63:0] PI_Q31    = 64'd6746518852;
	localparam logic [63:0] CURVE_DEN = 64'(2 * FULL_LEVEL);
	localparam logic [63:0] SERIES_DIV [1:12] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	// FULL_LEVEL * sin^2(pi*v/(2*FULL_LEVEL)) in Q31, Taylor series for sin
	function automatic curve_tab_t build_curve();
		curve_tab_t  tab;
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] sq;
		logic [63:0] val;
		for (int v = 0; v < CURVE_DEPTH; v++) begin
			if (v > FULL_LEVEL) begin
				tab[v] = '0;
			end else begin
				y    = (PI_Q31 * 64'(v)) / CURVE_DEN;
				y2   = (y * y) >> 31;
				term = y;
				sum  = y;
				for (int k = 1; k <= 12; k++) begin
					term = ((term * y2) >> 31) / SERIES_DIV[k];
					if ((k & 1) != 0) begin
						sum = sum - term;
					end else begin
						sum = sum + term;
					end
				end
				sq  = (sum * sum) >> 31;
				val = (64'(FULL_LEVEL) * sq + (64'd1 << 30)) >> 31;
				if (val > 64'(FULL_LEVEL)) begin
					val = 64'(FULL_LEVEL);
				end
				tab[v] = CURVE_W'(val);
			end
		end
		return tab;
	endfunction

endpackage
`default_nettype wire

// ----- src/mke_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mke_if: valid/ready channels of the key envelope engine
// Input beat carries one MIDI message or tick; output beat one key result.
// ----------------------------------------------------------------------------
interface mke_in_if import mke_pkg::*;;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [STAT_W-1:0] status_byte;
	logic [DATA_W-1:0] data_one;
	logic [DATA_W-1:0] data_two;
	logic [LEN_W-1:0]  msg_length;

	modport source (output valid, mode, status_byte, data_one, data_two, msg_length,
		input ready);
	modport sink (input valid, mode, status_byte, data_one, data_two, msg_length,
		output ready);
endinterface

interface mke_out_if import mke_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [KEY_W-1:0]         key_index;
	logic [LVL_W-1:0]         key_level;
	logic                     last_key;
	logic signed [BEND_W-1:0] bend_value;
	logic [MSQ_W-1:0]         master_level_sq;
	logic [PROG_W-1:0]        program_number;

	modport source (output valid, key_index, key_level, last_key, bend_value,
		master_level_sq, program_number, input ready);
	modport sink (input valid, key_index, key_level, last_key, bend_value,
		master_level_sq, program_number, output ready);
endinterface
`default_nettype wire

// ----- src/midi_key_envelope_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_key_envelope_engine: MIDI key envelope engine
// Tracks held keys from MIDI messages and, per tick, steps every key's level
// and emits it through a raised-cosine curve (uncurved above FULL_LEVEL), one beat per key.
// ----------------------------------------------------------------------------
//  port     | dir  | beat carries
//  ---------+------+---------------------------------------------------------
//  in_ch    | sink | one MIDI message (mode 0) or one envelope tick (mode 1)
//  out_ch   | src  | one key result: index, curved level, last flag, globals
//  cfg_*    | in   | register write: channel filter, transpose, percussion
//
//  A MIDI message is taken while idle and produces no beat.
//  A tick walks the keys lowest first through the level store, the shared
//  level unit and the curve ROM, stepping S_RD, S_UPD and S_CRV per key; S_CRV
//  waits while the output register is held by a stalled sink.
//  in_ch.ready is low for the whole walk; the last result may still wait.
//  Reset clears keys, levels (through per-key valid bits), globals and
//  registers at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module midi_key_envelope_engine import mke_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data,
	mke_in_if.sink                 in_ch,
	mke_out_if.source              out_ch
);

	// Sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_CRV  = 2'd3;

	logic [1:0]        state_q;
	logic [KEY_W-1:0]  key_q;
	logic [NOTE_W-1:0] note_q;
	logic [OCT_W-1:0]  oct_q;
	logic              perc_q;

	// Configuration
	logic [CHAN_W-1:0] chan_q;
	logic [TRN_W-1:0]  trn_q;
	logic [LVL_W-1:0]  perc_lvl_q;

	// Architectural state
	logic [NKEYS-1:0]  key_held_q;
	logic [HCNT_W-1:0] held_cnt_q;
	logic [NKEYS-1:0]  lvl_vld_q;
	logic [BEND_W-1:0] bend_q;
	logic [MSQ_W-1:0]  msq_q;
	logic [PROG_W-1:0] prog_q;

	// Level store and walk datapath
	logic [LVL_W-1:0]  smooth_mem [0:NKEYS-1];
	logic [LVL_W-1:0]  lvl_rd_q;
	logic              lvl_ok_q;
	logic [LVL_W-1:0]  lvl_new_q;
	logic              byp_q;
	logic [LVL_W-1:0]  lvl_cur;
	logic [LVL_W-1:0]  lvl_nxt;
	logic [LVL_W-1:0]  lvl_pick;
	lvl_ctl_t          ctl;
	logic [CURVE_AW-1:0] curve_addr;
	logic [CURVE_W-1:0]  curve_q;

	// Output register
	logic              out_vld_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [LVL_W-1:0]  out_lvl_q;
	logic              out_last_q;
	logic [BEND_W-1:0] out_bend_q;
	logic [MSQ_W-1:0]  out_msq_q;
	logic [PROG_W-1:0] out_prog_q;

	// Handshake
	logic in_fire;
	logic out_free;
	logic out_load;
	logic last_walk;

	// Message decode
	logic [3:0]        msg_type;
	logic              chan_ok;
	logic              len_full;
	logic signed [8:0] note_pos;
	logic              note_in;
	logic              note_msg;
	logic              note_new;
	logic              note_old;
	logic              all_off;
	logic              vol_msg;
	logic              bend_msg;
	logic              prog_msg;
	logic [KEY_W-1:0]  note_key;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_vld_q || out_ch.ready;
	assign out_load    = (state_q == S_CRV) && out_free;
	assign last_walk   = (key_q == KEY_W'(NKEYS - 1));

	// Filter the channel, transpose the note and sort the message by kind
	always_comb begin
		msg_type = in_ch.status_byte[7:4];
		chan_ok  = (chan_q == '0) || ((chan_q - CHAN_W'(1)) == {1'b0, in_ch.status_byte[3:0]});
		len_full = (in_ch.msg_length == LEN_FULL);
		note_pos = $signed({2'b00, in_ch.data_one}) + $signed({{4{trn_q[TRN_W-1]}}, trn_q})
			- $signed(9'(LOW_KEY));
		note_in  = !note_pos[8] && (note_pos[7:0] < 8'(NKEYS));
		note_key = note_pos[KEY_W-1:0];
		note_msg = chan_ok && len_full && note_in
			&& ((msg_type == MSG_NOTE_OFF) || (msg_type == MSG_NOTE_ON));
		note_new = (msg_type == MSG_NOTE_ON) && (in_ch.data_two != '0);
		note_old = key_held_q[note_key];
		all_off  = chan_ok && len_full && (msg_type == MSG_CTRL)
			&& (in_ch.data_one inside {CC_SOUND_OFF, CC_NOTES_OFF});
		vol_msg  = chan_ok && len_full && (msg_type == MSG_CTRL) && (in_ch.data_one == CC_VOLUME);
		bend_msg = chan_ok && len_full && (msg_type == MSG_BEND);
		prog_msg = chan_ok && (in_ch.msg_length == LEN_SHORT) && (msg_type == MSG_PROGRAM);
	end

	// Key under the walk: a level never written reads as zero
	always_comb begin
		lvl_cur    = lvl_ok_q ? lvl_rd_q : '0;
		ctl.held   = key_held_q[key_q];
		ctl.perc   = perc_q;
		ctl.oct    = oct_q;
		lvl_pick   = (state_q == S_UPD) ? lvl_nxt : lvl_new_q;
		curve_addr = (lvl_pick > LVL_W'(FULL_LEVEL)) ? '0 : lvl_pick[CURVE_AW-1:0];
	end

	mke_level_unit u_level (
		.ctl        (ctl),
		.lvl        (lvl_cur),
		.perc_level (perc_lvl_q),
		.lvl_nxt    (lvl_nxt)
	);

	// Curve is addressed in the update cycle, so its data lines up with S_CRV;
	// hold the address on the stored new level while the beat waits
	mke_curve_rom u_curve (
		.clk    (clk),
		.addr   (curve_addr),
		.data_q (curve_q)
	);

	// Level store: one write, one registered read
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			smooth_mem[key_q] <= lvl_nxt;
		end
		lvl_rd_q <= smooth_mem[key_q];
		lvl_ok_q <= lvl_vld_q[key_q];
		if (state_q == S_UPD) begin
			lvl_new_q <= lvl_nxt;
			byp_q     <= (lvl_nxt > LVL_W'(FULL_LEVEL));
		end
		if (out_load) begin
			out_key_q  <= key_q;
			out_lvl_q  <= byp_q ? lvl_new_q : LVL_W'(curve_q);
			out_last_q <= last_walk;
			out_bend_q <= bend_q;
			out_msq_q  <= msq_q;
			out_prog_q <= prog_q;
		end
	end

	// Sequencer, MIDI state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			key_q      <= '0;
			note_q     <= '0;
			oct_q      <= '0;
			perc_q     <= 1'b0;
			chan_q     <= '0;
			trn_q      <= '0;
			perc_lvl_q <= '0;
			key_held_q <= '0;
			held_cnt_q <= '0;
			lvl_vld_q  <= '0;
			bend_q     <= '0;
			msq_q      <= '0;
			prog_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIDI_CHANNEL: chan_q     <= cfg_data[CHAN_W-1:0];
					CFG_TRANSPOSE:    trn_q      <= cfg_data[TRN_W-1:0];
					CFG_PERCUSSION:   perc_lvl_q <= cfg_data[LVL_W-1:0];
					default: ;
				endcase
			end

			// Drop the output beat once taken, refill it from the walk
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire && in_ch.mode) begin
						// Percussion is judged on the keys held as the tick starts
						state_q <= S_RD;
						key_q   <= '0;
						note_q  <= '0;
						oct_q   <= '0;
						perc_q  <= (perc_lvl_q != '0) && (held_cnt_q == HCNT_W'(1));
					end else if (in_fire) begin
						if (note_msg) begin
							key_held_q[note_key] <= note_new;
							if (note_new && !note_old) begin
								held_cnt_q <= held_cnt_q + HCNT_W'(1);
							end else if (!note_new && note_old) begin
								held_cnt_q <= held_cnt_q - HCNT_W'(1);
							end
						end
						if (all_off) begin
							key_held_q <= '0;
							held_cnt_q <= '0;
						end
						if (vol_msg) begin
							msq_q <= MSQ_W'(in_ch.data_two) * MSQ_W'(in_ch.data_two);
						end
						if (bend_msg) begin
							bend_q <= {~in_ch.data_two[DATA_W-1], in_ch.data_two[DATA_W-2:0],
								in_ch.data_one};
						end
						if (prog_msg) begin
							prog_q <= in_ch.data_one;
						end
					end
				end
				S_RD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					lvl_vld_q[key_q] <= 1'b1;
					state_q          <= S_CRV;
				end
				S_CRV: begin
					if (out_free) begin
						if (last_walk) begin
							state_q <= S_IDLE;
						end else begin
							// Advance the key; roll the octave after twelve notes
							state_q <= S_RD;
							key_q   <= key_q + KEY_W'(1);
							if (note_q == NOTE_W'(OCT_KEYS - 1)) begin
								note_q <= '0;
								oct_q  <= oct_q + OCT_W'(1);
							end else begin
								note_q <= note_q + NOTE_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid           = out_vld_q;
	assign out_ch.key_index       = out_key_q;
	assign out_ch.key_level       = out_lvl_q;
	assign out_ch.last_key        = out_last_q;
	assign out_ch.bend_value      = $signed(out_bend_q);
	assign out_ch.master_level_sq = out_msq_q;
	assign out_ch.program_number  = out_prog_q;

endmodule
`default_nettype wire

// ----- src/mke_level_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mke_level_unit: shared envelope step
// Moves one key's level toward its target: rise by 5*step (or jump from zero to the percussion level), fall by step.
// ----------------------------------------------------------------------------
module mke_level_unit import mke_pkg::*; (
	input  wire lvl_ctl_t         ctl,
	input  wire logic [LVL_W-1:0] lvl,
	input  wire logic [LVL_W-1:0] perc_level,
	output logic      [LVL_W-1:0] lvl_nxt
);

	logic [STEP_W-1:0] step;
	logic [LVL_W-1:0]  step_ext;
	logic [LVL_W-1:0]  target;
	logic [LVL_W-1:0]  rise;

	always_comb begin
		step     = STEP_W'(1) << ctl.oct;
		step_ext = LVL_W'(step);
		target   = ctl.held ? LVL_W'(FULL_LEVEL) : '0;
		rise     = lvl + (step_ext << 2) + step_ext;
		if (lvl < target) begin
			if (ctl.perc && (lvl == '0)) begin
				lvl_nxt = perc_level;
			end else begin
				lvl_nxt = rise;
			end
		end else if (lvl > target) begin
			lvl_nxt = (lvl > step_ext) ? (lvl - step_ext) : '0;
		end else begin
			lvl_nxt = lvl;
		end
	end

endmodule
`default_nettype wire

// ----- src/mke_curve_rom.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mke_curve_rom: raised-cosine level curve
// Constant table with a registered read port.
// ----------------------------------------------------------------------------
module mke_curve_rom import mke_pkg::*; (
	input  wire                      clk,
	input  wire logic [CURVE_AW-1:0] addr,
	output logic      [CURVE_W-1:0]  data_q
);

	localparam curve_tab_t SOFT_CURVE = build_curve();

	always_ff @(posedge clk) begin
		data_q <= SOFT_CURVE[addr];
	end

endmodule
`default_nettype wire

// ----- src/mke_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mke_checker: port-level checks of the key envelope engine
// Watches the channel handshakes and the shape of a tick's result beats.
// ----------------------------------------------------------------------------
module mke_checker import mke_pkg::*; (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   in_valid,
	input wire                   in_ready,
	input wire                   in_mode,
	input wire                   out_valid,
	input wire                   out_ready,
	input wire logic [KEY_W-1:0] out_key_index,
	input wire                   out_last_key
);

	// Last flag marks exactly the top key
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last_key == (out_key_index == KEY_W'(NKEYS - 1))))
		else $error("last_key does not match the top key");

	// A non-final key result means a tick is still walking: no input taken
	a_busy_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_last_key) |-> !in_ready)
		else $error("input ready while a tick is still in progress");

	// An accepted tick closes the input
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_mode) |=> !in_ready)
		else $error("input ready straight after a tick beat");

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_key_index)))
		else $error("stalled result beat changed");

endmodule

bind midi_key_envelope_engine mke_checker u_mke_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.in_mode       (in_ch.mode),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_key_index (out_ch.key_index),
	.out_last_key  (out_ch.last_key)
);
`default_nettype wire
